// ===== sv/f2h_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared constants for the float32 to half-precision texel packer.
// ----------------------------------------------------------------------------
package f2h_pkg;

    localparam int LANES    = 4;
    localparam int F32_W    = 32;
    localparam int HALF_W   = 16;
    localparam int IN_W     = LANES * F32_W;
    localparam int OUT_W    = LANES * HALF_W;

    localparam logic [15:0] HALF_SIGN     = 16'h8000;
    localparam logic [14:0] HALF_QNAN     = 15'h7e00;
    localparam logic [14:0] HALF_INF      = 15'h7c00;
    localparam logic [15:0] HALF_MAX_BITS = 16'h7bff;
    localparam logic [22:0] F32_MANT_MASK = 23'h7fffff;
    localparam logic [23:0] ROUND_HALF    = 24'h001000;
    localparam logic [31:0] F32_MAX_HALF  = 32'h477fe000;

    // Biased float32 exponent thresholds (float32 bias 127, half bias 15)
    localparam logic [7:0] EXP_ALL_ONES = 8'hff;
    localparam logic [7:0] EXP_OVF      = 8'd143;  // half exponent 31
    localparam logic [7:0] EXP_NORM_MIN = 8'd113;  // half exponent 1
    localparam logic [7:0] EXP_SUB_MIN  = 8'd102;  // half exponent -10
    localparam logic [7:0] EXP_REBIAS   = 8'd112;  // 127 - 15

endpackage : f2h_pkg
`default_nettype wire

// ===== sv/float32_to_half_packer.sv =====
// An accepted item is loaded into the output register, or into the skid
// register if the output is stalled. Throughput: one texel per cycle while
// m_tready is high; lanes are combinational ahead of the output register.
// Reset: synchronous active-low aresetn empties the output and skid stages
// and sets clamp_mode to 1.
`default_nettype none
// ----------------------------------------------------------------------------
// float32_to_half_packer
// Converts four float32 texel channels to half precision per item.
// ----------------------------------------------------------------------------
module float32_to_half_packer (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // value_0 [31:0], value_1 [63:32], value_2 [95:64], value_3 [127:96]
    input  wire logic [f2h_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // half_0 [15:0], half_1 [31:16], half_2 [47:32], half_3 [63:48]
    output logic      [f2h_pkg::OUT_W-1:0] m_tdata,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_data
);
    import f2h_pkg::*;

    logic             clamp_mode_reg;
    logic [OUT_W-1:0] lane_halves;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clamp_mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            clamp_mode_reg <= cfg_data;
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        f2h_lane u_lane (
            .bits       (s_tdata[i*F32_W +: F32_W]),
            .clamp_mode (clamp_mode_reg),
            .half       (lane_halves[i*HALF_W +: HALF_W])
        );
    end

    f2h_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (lane_halves),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // after an accept, m_tvalid is high next cycle
    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item not presented");

    // the skid stage fills only behind a stalled output
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready) |-> (m_tvalid && $past(m_tvalid && !m_tready)))
        else $error("skid full without stalled output");

    // a full skid drains into the output once the output moves
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && m_tready) |=> (s_tready && m_tvalid))
        else $error("skid not drained");

endmodule : float32_to_half_packer
`default_nettype wire

// ===== sv/f2h_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// f2h_lane
// One float32 to float16 conversion lane, with optional clamp/sanitize.
// ----------------------------------------------------------------------------
module f2h_lane (
    input  wire logic [f2h_pkg::F32_W-1:0]  bits,
    input  wire logic                       clamp_mode,
    output logic      [f2h_pkg::HALF_W-1:0] half
);
    import f2h_pkg::*;

    logic        sign;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [3:0]  sh;
    logic [23:0] sub_shift;
    logic [23:0] sub_round;
    logic [23:0] norm_round;
    logic [4:0]  he;
    logic [14:0] norm_mag;
    logic [15:0] raw_half;

    always_comb begin
        sign       = bits[31];
        expo       = bits[30:23];
        mant       = bits[22:0] & F32_MANT_MASK;
        sh         = 4'(EXP_NORM_MIN - expo);
        sub_shift  = {1'b1, mant} >> sh;
        sub_round  = sub_shift + ROUND_HALF;
        norm_round = {1'b0, mant} + ROUND_HALF;
        he         = 5'(expo - EXP_REBIAS);
        // rounding carry adds into the exponent field
        norm_mag   = {he, 10'd0} + {4'd0, norm_round[23:13]};

        if (expo == EXP_ALL_ONES) begin
            raw_half = {sign, (mant != '0) ? HALF_QNAN : HALF_INF};
        end else if (expo >= EXP_OVF) begin
            raw_half = {sign, HALF_INF};
        end else if (expo < EXP_SUB_MIN) begin
            raw_half = {sign, 15'd0};
        end else if (expo < EXP_NORM_MIN) begin
            raw_half = {sign, 4'd0, sub_round[23:13]};
        end else begin
            raw_half = {sign, norm_mag};
        end

        if (clamp_mode && ((expo == EXP_ALL_ONES) || sign)) begin
            half = '0;
        end else if (clamp_mode && (bits > F32_MAX_HALF)) begin
            half = HALF_MAX_BITS;
        end else begin
            half = raw_half;
        end
    end

endmodule : f2h_lane
`default_nettype wire

// ===== sv/f2h_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// f2h_merge
// Collects the lane results into one item; output register plus skid stage.
// ----------------------------------------------------------------------------
module f2h_merge (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [f2h_pkg::OUT_W-1:0] in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [f2h_pkg::OUT_W-1:0] out_data
);
    import f2h_pkg::*;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg,  out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0] skid_data_reg,  skid_data_next;
    logic             take_in;
    logic             take_out;

    assign in_ready  = !skid_valid_reg;
    assign take_in   = in_valid && in_ready;
    assign take_out  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take_out) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = take_in;
                out_data_next  = in_data;
            end
        end else if (take_in) begin
            // output stalled: park the item
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule : f2h_merge
`default_nettype wire

// ===== tb/tb_float32_to_half_packer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float32_to_half_packer
// Streams RGBA texels of float32 bit patterns through the packer and checks
// every half-precision lane against typed-in or in-bench converted halves,
// in both clamp and raw modes, with random stalls on input and output.
// ----------------------------------------------------------------------------
module tb_float32_to_half_packer;
    import f2h_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int NUM_PHASES  = 4;

    typedef logic [OUT_W-1:0] halves_t;

    typedef struct packed {
        logic              clamp;
        logic [IN_W-1:0]   texel;   // {lane 3, lane 2, lane 1, lane 0}
        logic              fixed;   // halves typed in below
        halves_t           halves;  // {lane 3, lane 2, lane 1, lane 0}
    } texel_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;

    logic    clamp_mode_shadow;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;
    bit      quiet = 1'b0;
    int      mismatch_count = 0;
    int      stall_cycles = 0;
    halves_t pending_halves[$];

    texel_row_t texel_tbl [13] = '{
        // clamp mode: zeros, infinity and NaN all go to +0
        '{1'b1, {32'h7fc00001, 32'h7f800000, 32'h80000000, 32'h00000000},
          1'b1, {16'h0000, 16'h0000, 16'h0000, 16'h0000}},
        '{1'b1, {32'h477fe001, 32'h477fe000, 32'hbf800000, 32'h3f800000},
          1'b1, {16'h7bff, 16'h7bff, 16'h0000, 16'h3c00}},
        '{1'b1, {32'h80000001, 32'h00000001, 32'hff800000, 32'h7f7fffff},
          1'b1, {16'h0000, 16'h0000, 16'h0000, 16'h7bff}},
        '{1'b1, {32'h477ff000, 32'h3f801000, 32'h387fe000, 32'h33800000},
          1'b0, '0},
        // raw mode
        '{1'b0, {32'hff800000, 32'h7f800000, 32'h80000000, 32'h00000000},
          1'b1, {16'hfc00, 16'h7c00, 16'h8000, 16'h0000}},
        '{1'b0, {32'h3f800000, 32'h7fc00000, 32'hffffffff, 32'h7f800001},
          1'b1, {16'h3c00, 16'h7e00, 16'hfe00, 16'h7e00}},
        '{1'b0, {32'h7f7fffff, 32'h00800000, 32'h80000001, 32'h00000001},
          1'b1, {16'h7c00, 16'h0000, 16'h8000, 16'h0000}},
        // rounding carry into infinity, overflow
        '{1'b0, {32'h47800000, 32'hc77ff000, 32'h477ff000, 32'h477fe000},
          1'b0, '0},
        // subnormal edges, rounding into the smallest normal
        '{1'b0, {32'h387fe000, 32'hb3800000, 32'h337fffff, 32'h33800000},
          1'b0, '0},
        '{1'b0, {32'h3f800fff, 32'h3f801000, 32'h38800000, 32'h387fffff},
          1'b0, '0},
        '{1'b0, {32'h7fffffff, 32'h55555555, 32'haaaaaaaa, 32'hffffffff},
          1'b0, '0},
        '{1'b1, {32'h477fefff, 32'h387fe000, 32'hc7800000, 32'h80000001},
          1'b0, '0},
        '{1'b1, {32'h00000000, 32'h55555555, 32'haaaaaaaa, 32'hffffffff},
          1'b0, '0}
    };

    int   phase_items [NUM_PHASES] = '{500, 500, 340, 300};
    logic phase_clamp [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1};

    float32_to_half_packer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [15:0] half_from_f32(input logic [31:0] bits, input logic clamp);
        logic [15:0] sgn;
        logic [7:0]  ex;
        int          he;
        logic [31:0] rnd;
        sgn = bits[31] ? HALF_SIGN : 16'h0000;
        ex  = bits[30:23];
        if (clamp) begin
            if (ex == EXP_ALL_ONES || bits[31])
                return 16'h0000;
            if (bits > F32_MAX_HALF)
                return HALF_MAX_BITS;
        end
        if (ex == EXP_ALL_ONES)
            return sgn | {1'b0, (bits[22:0] != 23'h0) ? HALF_QNAN : HALF_INF};
        he = int'(ex) - int'(EXP_REBIAS);
        if (he >= 31)
            return sgn | {1'b0, HALF_INF};
        if (he < -10)
            return sgn;
        if (he <= 0) begin
            // hidden bit restored, shifted bits dropped without sticky
            rnd = (32'({1'b1, bits[22:0]}) >> (1 - he)) + 32'(ROUND_HALF);
            return sgn | rnd[28:13];
        end
        // a carry out of the mantissa lands in the exponent
        rnd = 32'(bits[22:0]) + 32'(ROUND_HALF);
        return sgn + 16'(he << 10) + rnd[28:13];
    endfunction

    function automatic halves_t texel_halves(input logic [IN_W-1:0] texel, input logic clamp);
        halves_t h;
        for (int l = 0; l < LANES; l++)
            h[l*HALF_W +: HALF_W] = half_from_f32(texel[l*F32_W +: F32_W], clamp);
        return h;
    endfunction

    // Mostly values in or near the half range, with specials and rounding edges
    function automatic logic [31:0] rand_lane();
        logic        s;
        logic [22:0] m;
        s = 1'($urandom_range(0, 1));
        m = 23'($urandom());
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2, 3, 4, 5, 6: return {s, 8'($urandom_range(100, 145)), m};
            7: return {s, ($urandom_range(0, 1) != 0) ? EXP_ALL_ONES : 8'h00,
                       ($urandom_range(0, 3) == 0) ? 23'h0 : m};
            8: return {s, 8'($urandom_range(100, 143)), m[22:13],
                       ($urandom_range(0, 1) != 0) ? 13'h1000 : 13'h0fff};
            default: return {s, 31'(F32_MAX_HALF - 32'h1000 + $urandom_range(0, 32'h2000))};
        endcase
    endfunction

    task automatic send_texel(input logic [IN_W-1:0] texel, input logic fixed,
                              input halves_t fixed_halves);
        s_tvalid <= 1'b1;
        s_tdata  <= texel;
        do @(posedge aclk); while (!s_tready);
        pending_halves = {pending_halves,
                          (fixed ? fixed_halves : texel_halves(texel, clamp_mode_shadow))};
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_halves.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_clamp(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        clamp_mode_shadow = mode;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        clamp_mode_shadow = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (texel_tbl[i]) begin
            if (texel_tbl[i].clamp != clamp_mode_shadow) begin
                wait_drained();
                write_clamp(texel_tbl[i].clamp);
            end
            sender_gap();
            send_texel(texel_tbl[i].texel, texel_tbl[i].fixed, texel_tbl[i].halves);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_clamp(phase_clamp[p]);
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == 100)
                    hold_req = 1'b1;    // keep offering while the output is held off
                else if (p == 1 && n == 250)
                    wait_drained();
                else if (!hold_req || hold_done)
                    sender_gap();
                send_texel({rand_lane(), rand_lane(), rand_lane(), rand_lane()}, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_halves.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        halves_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_halves.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: got %h", m_tdata);
            end else begin
                want = pending_halves.pop_front();
                for (int l = 0; l < LANES; l++) begin
                    if (m_tdata[l*HALF_W +: HALF_W] !== want[l*HALF_W +: HALF_W]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("half_%0d mismatch: expected %h, got %h", l,
                                     want[l*HALF_W +: HALF_W], m_tdata[l*HALF_W +: HALF_W]);
                    end
                end
            end
        end
    end

    // no handshake on any channel for too long means the block hung
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
